>>> design/pls_pkg.sv
package pls_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the channels
    localparam int OP_W  = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;
    localparam int TOT_W = 7;

    // Width wide enough to compare a position against the entry count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_POS  = 3'd2,
        OP_READ     = 3'd3,
        OP_DEL_HEAD = 3'd4,
        OP_DEL_TAIL = 3'd5,
        OP_DEL_POS  = 3'd6
    } op_t;

    typedef enum logic [STS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Work left to do for an accepted transaction
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_READ,
        ACT_DELETE
    } act_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_SHIFT,
        S_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic idle;
        logic mem_rd;
        logic shift_wr;
        logic put;
        logic cnt_dec;
        logic res_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic take;
        act_t act;
        logic more;
        logic out_free;
    } sts_t;

endpackage

>>> design/pls_chan_if.sv
interface pls_req_if;
    logic                           valid;
    logic                           ready;
    logic [pls_pkg::OP_W-1:0]       operation;
    logic [pls_pkg::POS_W-1:0]      position;
    logic signed [pls_pkg::VAL_W-1:0] item_value;

    modport source (output valid, output operation, output position, output item_value,
                    input ready);
    modport sink (input valid, input operation, input position, input item_value,
                  output ready);
endinterface

interface pls_rsp_if;
    logic                           valid;
    logic                           ready;
    logic signed [pls_pkg::VAL_W-1:0] read_value;
    logic [pls_pkg::STS_W-1:0]      status;
    logic [pls_pkg::TOT_W-1:0]      entry_total;

    modport source (output valid, output read_value, output status, output entry_total,
                    input ready);
    modport sink (input valid, input read_value, input status, input entry_total,
                  output ready);
endinterface

>>> design/pls_dp.sv
module pls_dp (
    input  logic           clk,
    input  logic           rst_n,
    pls_req_if.sink        req,
    pls_rsp_if.source      rsp,
    input  pls_pkg::cmd_t  cmd,
    output pls_pkg::sts_t  sts
);

    logic [pls_pkg::VAL_W-1:0] mem [pls_pkg::CAPACITY];

    logic [pls_pkg::CNT_W-1:0]  count_reg;
    pls_pkg::act_t              act_reg;
    pls_pkg::status_t           stat_reg;
    logic [pls_pkg::CNT_W-1:0]  tpos_reg;
    logic [pls_pkg::CNT_W-1:0]  idx_reg;
    logic [pls_pkg::VAL_W-1:0]  val_reg;
    logic [pls_pkg::VAL_W-1:0]  rdata_reg;

    logic                       out_valid_reg;
    logic [pls_pkg::VAL_W-1:0]  out_val_reg;
    pls_pkg::status_t           out_stat_reg;
    logic [pls_pkg::TOT_W-1:0]  out_tot_reg;

    logic                       take;
    logic [pls_pkg::CMP_W-1:0]  pos_ext;
    logic [pls_pkg::CMP_W-1:0]  cnt_ext;
    logic [pls_pkg::CMP_W-1:0]  ins_pos;
    logic                       is_ins;
    pls_pkg::act_t              ev_act;
    pls_pkg::status_t           ev_stat;
    logic [pls_pkg::CNT_W-1:0]  ev_tpos;
    logic [pls_pkg::CNT_W-1:0]  idx_dn;
    logic [pls_pkg::CNT_W:0]    idx_up;
    logic [pls_pkg::ADDR_W-1:0] rd_addr;
    logic [pls_pkg::ADDR_W-1:0] wr_addr;
    logic [pls_pkg::VAL_W-1:0]  wr_data;
    logic                       wr_en;
    logic                       more;
    logic                       cnt_empty;
    logic                       cnt_full;

    assign take      = req.valid && cmd.idle;
    assign req.ready = cmd.idle;

    assign pos_ext   = pls_pkg::CMP_W'(req.position);
    assign cnt_ext   = pls_pkg::CMP_W'(count_reg);
    assign cnt_empty = (count_reg == '0);
    assign cnt_full  = (count_reg == pls_pkg::CNT_W'(pls_pkg::CAPACITY));

    // Classify the incoming transaction against the current count
    always_comb
    begin
        ev_act  = pls_pkg::ACT_NONE;
        ev_stat = pls_pkg::ST_OK;
        ev_tpos = '0;
        is_ins  = 1'b0;
        ins_pos = '0;
        case (pls_pkg::op_t'(req.operation))
            pls_pkg::OP_INS_HEAD:
            begin
                is_ins  = 1'b1;
                ins_pos = '0;
            end
            pls_pkg::OP_INS_TAIL:
            begin
                is_ins  = 1'b1;
                ins_pos = cnt_ext;
            end
            pls_pkg::OP_INS_POS:
            begin
                is_ins  = 1'b1;
                ins_pos = pos_ext;
            end
            pls_pkg::OP_READ:
            begin
                if (pos_ext < cnt_ext)
                begin
                    ev_act  = pls_pkg::ACT_READ;
                    ev_tpos = pls_pkg::CNT_W'(pos_ext);
                end
                else
                begin
                    ev_stat = pls_pkg::ST_BAD_INDEX;
                end
            end
            pls_pkg::OP_DEL_HEAD:
            begin
                if (cnt_empty)
                begin
                    ev_stat = pls_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    ev_act  = pls_pkg::ACT_DELETE;
                    ev_tpos = '0;
                end
            end
            pls_pkg::OP_DEL_TAIL:
            begin
                if (cnt_empty)
                begin
                    ev_stat = pls_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    ev_act  = pls_pkg::ACT_DELETE;
                    ev_tpos = count_reg - pls_pkg::CNT_W'(1);
                end
            end
            pls_pkg::OP_DEL_POS:
            begin
                if (pos_ext < cnt_ext)
                begin
                    ev_act  = pls_pkg::ACT_DELETE;
                    ev_tpos = pls_pkg::CNT_W'(pos_ext);
                end
                else
                begin
                    ev_stat = pls_pkg::ST_BAD_INDEX;
                end
            end
            default:
            begin
                ev_act = pls_pkg::ACT_NONE;
            end
        endcase

        // Bad position wins over a full store
        if (is_ins)
        begin
            if (ins_pos > cnt_ext)
            begin
                ev_stat = pls_pkg::ST_BAD_INDEX;
            end
            else if (cnt_full)
            begin
                ev_stat = pls_pkg::ST_FULL;
            end
            else
            begin
                ev_act  = pls_pkg::ACT_INSERT;
                ev_tpos = pls_pkg::CNT_W'(ins_pos);
            end
        end
    end

    // Latch the transaction and its classification
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= pls_pkg::ACT_NONE;
        end
        else if (take)
        begin
            act_reg <= ev_act;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stat_reg <= ev_stat;
            tpos_reg <= ev_tpos;
            val_reg  <= req.item_value;
        end
    end

    // Shift cursor: inserts walk down from the tail, deletes walk up from the hole
    assign idx_dn = idx_reg - pls_pkg::CNT_W'(1);
    assign idx_up = {1'b0, idx_reg} + (pls_pkg::CNT_W + 1)'(1);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            idx_reg <= (ev_act == pls_pkg::ACT_INSERT) ? count_reg : ev_tpos;
        end
        else if (cmd.shift_wr)
        begin
            idx_reg <= (act_reg == pls_pkg::ACT_INSERT) ? idx_dn
                                                       : idx_up[pls_pkg::CNT_W-1:0];
        end
    end

    always_comb
    begin
        case (act_reg)
            pls_pkg::ACT_INSERT: more = (idx_reg > tpos_reg);
            pls_pkg::ACT_DELETE: more = (idx_up < {1'b0, count_reg});
            default:             more = 1'b0;
        endcase
    end

    // Memory addressing
    always_comb
    begin
        case (act_reg)
            pls_pkg::ACT_INSERT: rd_addr = idx_dn[pls_pkg::ADDR_W-1:0];
            pls_pkg::ACT_DELETE: rd_addr = idx_up[pls_pkg::ADDR_W-1:0];
            default:             rd_addr = tpos_reg[pls_pkg::ADDR_W-1:0];
        endcase
    end

    assign wr_en   = cmd.shift_wr || cmd.put;
    assign wr_addr = cmd.put ? tpos_reg[pls_pkg::ADDR_W-1:0] : idx_reg[pls_pkg::ADDR_W-1:0];
    assign wr_data = cmd.put ? val_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.put)
        begin
            count_reg <= count_reg + pls_pkg::CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_reg <= count_reg - pls_pkg::CNT_W'(1);
        end
    end

    // Output register: hold the result until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            if (act_reg == pls_pkg::ACT_READ)
            begin
                out_val_reg <= rdata_reg;
            end
            else if (stat_reg != pls_pkg::ST_OK)
            begin
                out_val_reg <= '1;
            end
            else
            begin
                out_val_reg <= '0;
            end
            out_stat_reg <= stat_reg;
            out_tot_reg  <= pls_pkg::TOT_W'(count_reg);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_val_reg;
    assign rsp.status      = out_stat_reg;
    assign rsp.entry_total = out_tot_reg;

    assign sts.take     = take;
    assign sts.act      = act_reg;
    assign sts.more     = more;
    assign sts.out_free = !out_valid_reg || rsp.ready;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pls_pkg::CNT_W'(pls_pkg::CAPACITY))
        else $error("entry count exceeds capacity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || rsp.ready))
        else $error("result loaded over a pending result");

    a_put_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |=> (count_reg == $past(count_reg) + pls_pkg::CNT_W'(1)))
        else $error("insert did not advance the count");

    a_shift_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> (act_reg == pls_pkg::ACT_INSERT || act_reg == pls_pkg::ACT_DELETE))
        else $error("shift outside an insert or delete");
`endif

endmodule

>>> design/pls_ctrl.sv
module pls_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  pls_pkg::sts_t  sts,
    output pls_pkg::cmd_t  cmd
);

    pls_pkg::state_t state_reg;
    pls_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pls_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            pls_pkg::S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.take)
                begin
                    state_next = pls_pkg::S_STEP;
                end
            end
            pls_pkg::S_STEP:
            begin
                case (sts.act)
                    pls_pkg::ACT_INSERT:
                    begin
                        if (sts.more)
                        begin
                            cmd.mem_rd = 1'b1;
                            state_next = pls_pkg::S_SHIFT;
                        end
                        else
                        begin
                            cmd.put    = 1'b1;
                            state_next = pls_pkg::S_FINISH;
                        end
                    end
                    pls_pkg::ACT_DELETE:
                    begin
                        if (sts.more)
                        begin
                            cmd.mem_rd = 1'b1;
                            state_next = pls_pkg::S_SHIFT;
                        end
                        else
                        begin
                            cmd.cnt_dec = 1'b1;
                            state_next  = pls_pkg::S_FINISH;
                        end
                    end
                    pls_pkg::ACT_READ:
                    begin
                        cmd.mem_rd = 1'b1;
                        state_next = pls_pkg::S_FINISH;
                    end
                    default:
                    begin
                        state_next = pls_pkg::S_FINISH;
                    end
                endcase
            end
            pls_pkg::S_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = pls_pkg::S_STEP;
            end
            pls_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = pls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pls_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> design/positional_list_store_core.sv
// Ordered list of signed 32-bit entries kept in a store of CAPACITY slots.
// req channel: one transaction carries operation, position and item_value
// (insert head/tail/at position, read, delete head/tail/at position).
// rsp channel: exactly one transaction per request, carrying read_value,
// status and entry_total (count after the operation), in request order.
// Sequence: a request is taken in the idle cycle, then the slot memory
// moves the entries one at a time, each by a registered read, then a write.
// A request that moves k entries does k read/write pairs; reads, rejected
// requests and tail operations move no entries.
// The next request is accepted the cycle after the result is loaded, so
// requests are worked in the store one at a time.
// Reset empties the list at once; slot contents stay undefined and are
// never read before being written, so no clearing pass is needed.
// If the receiver stalls, the result waits in the output register while
// the next request is accepted and worked; that request then holds in its
// final step until the output register frees.
module positional_list_store_core (
    input  logic       clk,
    input  logic       rst_n,
    pls_req_if.sink    req,
    pls_rsp_if.source  rsp
);

    pls_pkg::cmd_t cmd;
    pls_pkg::sts_t sts;

    pls_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    pls_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule
